@@ rtl/core/cwvb_pkg.sv @@
// ============================================================================
// cwvb_pkg: shared types and helpers for the control word validator
// Holds the status codes, sequencer states, walk token type and the
// byte checksum test used when a control word is checked.
// ============================================================================
`default_nettype none

package cwvb_pkg;

    // control word geometry
    localparam int CW_BITS     = 128;
    localparam int BYTE_BITS   = 8;
    localparam int GROUP_COUNT = 4;
    localparam int GROUP_BYTES = 4;

    // result codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CHECKSUM = 2'd1,
        STATUS_NULL     = 2'd2,
        STATUS_BLACK    = 2'd3
    } status_t;

    // input kinds carried on tuser
    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_ADD   = 1'b1
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } state_t;

    // token that walks the cell row during a lookup
    typedef struct packed {
        logic tok;
        logic hit;
    } walk_t;

    // checksum and null test; ok means the word still needs a history lookup
    function automatic status_t check_word(input logic [CW_BITS-1:0] word);
        status_t             res;
        logic                bad;
        logic [BYTE_BITS-1:0] sum;
        res = STATUS_OK;
        bad = 1'b0;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            sum = word[(g*GROUP_BYTES)*BYTE_BITS +: BYTE_BITS]
                + word[(g*GROUP_BYTES+1)*BYTE_BITS +: BYTE_BITS]
                + word[(g*GROUP_BYTES+2)*BYTE_BITS +: BYTE_BITS];
            if (sum != word[(g*GROUP_BYTES+3)*BYTE_BITS +: BYTE_BITS]) begin
                bad = 1'b1;
            end
        end
        if (bad) begin
            res = STATUS_CHECKSUM;
        end else if (word == '0) begin
            res = STATUS_NULL;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/control_word_validator_blacklist.sv @@
// ============================================================================
// control_word_validator_blacklist: checksum test and blacklist lookup
// Checks 16-byte control words for group checksums, null words and a
// match in a shifting history of blacklisted words; adds words to it.
// ============================================================================
//
//  channel  | dir | beat contents
//  ---------+-----+---------------------------------------------------------
//  s_       | in  | tdata: cw_low[63:0], cw_high[127:64]; tuser: op
//  m_       | out | tdata: status[1:0], zeros[7:2]
//
//  an add, or a check that fails the checksum or null test, goes from the
//  accept edge to ST_RESULT and loads its result beat into the output register,
//  which frees the input; a check that reaches the history lookup first waits
//  in ST_WALK for the token walking the cell row one cell per cycle to leave
//  the last cell, and holds the input until then. one beat is worked on at a
//  time; the result register frees the input side while a result waits.
//  reset clears the fill count, so the history reads as empty right after
//  reset, with no clearing pass.
//
`default_nettype none

module control_word_validator_blacklist #(
    parameter int HISTORY_DEPTH = 32
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [127:0] s_tdata,   // cw_low[63:0], cw_high[127:64]
    input  wire  [0:0]   s_tuser,   // op[0]
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [7:0]   m_tdata    // status[1:0], zero pad[7:2]
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    cwvb_pkg::state_t            state_reg, state_next;
    logic [cwvb_pkg::CW_BITS-1:0] query_reg;
    logic                         start_reg, start_next;
    cwvb_pkg::status_t           res_reg, res_next;
    logic [CNT_W-1:0]             fill_count_reg;
    logic                         m_valid_reg;
    cwvb_pkg::status_t           m_status_reg;

    logic                         accept;
    logic                         shift_en;
    logic                         out_load;
    cwvb_pkg::status_t           chk;

    logic [cwvb_pkg::CW_BITS-1:0] dchain [0:HISTORY_DEPTH];
    cwvb_pkg::walk_t             wchain [0:HISTORY_DEPTH];

    assign accept   = s_tvalid & s_tready;
    assign s_tready = (state_reg == cwvb_pkg::ST_IDLE);
    assign chk      = cwvb_pkg::check_word(s_tdata);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        start_next = 1'b0;
        shift_en   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            cwvb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (cwvb_pkg::op_t'(s_tuser[0]) == cwvb_pkg::OP_ADD) begin
                        shift_en   = 1'b1;
                        res_next   = cwvb_pkg::STATUS_OK;
                        state_next = cwvb_pkg::ST_RESULT;
                    end else if (chk != cwvb_pkg::STATUS_OK) begin
                        res_next   = chk;
                        state_next = cwvb_pkg::ST_RESULT;
                    end else begin
                        start_next = 1'b1;
                        state_next = cwvb_pkg::ST_WALK;
                    end
                end
            end
            cwvb_pkg::ST_WALK: begin
                if (wchain[HISTORY_DEPTH].tok) begin
                    res_next   = wchain[HISTORY_DEPTH].hit ? cwvb_pkg::STATUS_BLACK
                                                           : cwvb_pkg::STATUS_OK;
                    state_next = cwvb_pkg::ST_RESULT;
                end
            end
            cwvb_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = cwvb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cwvb_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cwvb_pkg::ST_IDLE;
            start_reg      <= 1'b0;
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            if (shift_en && (fill_count_reg != CNT_W'(HISTORY_DEPTH))) begin
                fill_count_reg <= fill_count_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (accept) begin
            query_reg <= s_tdata;
        end
        if (out_load) begin
            m_status_reg <= res_reg;
        end
    end

    // head of the row: new words enter here, the token starts here
    assign dchain[0] = s_tdata;
    assign wchain[0] = '{tok: start_reg, hit: 1'b0};

    // row of history cells, newest at the head, oldest falls off the tail
    for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
        cwvb_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (shift_en),
            .entry_valid (fill_count_reg > CNT_W'(i)),
            .query       (query_reg),
            .d_in        (dchain[i]),
            .d_out       (dchain[i+1]),
            .walk_in     (wchain[i]),
            .walk_out    (wchain[i+1])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_status_reg};

endmodule

`default_nettype wire

@@ rtl/core/cwvb_cell.sv @@
// ============================================================================
// cwvb_cell: one history entry of the blacklist row
// Stores one control word, shifts it to the next cell on an add, and
// compares it with the broadcast query when the walk token passes by.
// ============================================================================
`default_nettype none

module cwvb_cell (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          shift_en,
    input  wire                          entry_valid,
    input  wire  [cwvb_pkg::CW_BITS-1:0] query,
    input  wire  [cwvb_pkg::CW_BITS-1:0] d_in,
    output logic [cwvb_pkg::CW_BITS-1:0] d_out,
    input  wire  cwvb_pkg::walk_t        walk_in,
    output cwvb_pkg::walk_t              walk_out
);

    logic [cwvb_pkg::CW_BITS-1:0] entry_reg;
    cwvb_pkg::walk_t              walk_reg;
    cwvb_pkg::walk_t              walk_next;

    // entry storage, shifted along the row on every add
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= d_in;
        end
    end

    // compare against the query as the token passes
    always_comb begin
        walk_next.tok = walk_in.tok;
        walk_next.hit = walk_in.tok &
                        (walk_in.hit | (entry_valid & (entry_reg == query)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= '0;
        end else begin
            walk_reg <= walk_next;
        end
    end

    assign d_out    = entry_reg;
    assign walk_out = walk_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_control_word_validator_blacklist.sv @@
// ============================================================================
// tb_control_word_validator_blacklist: stream testbench for the validator
// Drives check and add beats with bursty input and a stalling receiver,
// predicts each status from its own copy of the blacklist history and
// compares every result beat against the oldest pending prediction.
// ============================================================================
`default_nettype none

module tb_control_word_validator_blacklist;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH = 32;
    localparam int WORD_CAP   = 64;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // cw_low[63:0], cw_high[127:64]
    logic [0:0]   s_tuser;   // op[0]
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;   // status[1:0], zero pad[7:2]

    // predictor copy of the blacklist history
    logic [63:0]  bl_low [HIST_DEPTH];
    logic [63:0]  bl_high[HIST_DEPTH];
    int           bl_fill;
    int           bl_slot;

    cwvb_pkg::status_t status_expected[$];
    logic [127:0] added_words[$];
    int           mismatches;

    // sender burst shaping
    int           burst_left;
    bit           sender_steady;

    // receiver stall pattern
    int           rx_mode;
    int           rx_cycle;

    control_word_validator_blacklist #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // expected status of one beat, updates the history copy on an add
    function automatic cwvb_pkg::status_t predict_status(cwvb_pkg::op_t op,
                                                         logic [127:0] word);
        cwvb_pkg::status_t res;
        logic [7:0]        sum;
        logic              bad;
        res = cwvb_pkg::STATUS_OK;
        bad = 1'b0;
        if (op == cwvb_pkg::OP_ADD) begin
            bl_low[bl_slot]  = word[63:0];
            bl_high[bl_slot] = word[127:64];
            bl_slot = (bl_slot == HIST_DEPTH - 1) ? 0 : bl_slot + 1;
            if (bl_fill < HIST_DEPTH) begin
                bl_fill++;
            end
        end else begin
            for (int g = 0; g < 4; g++) begin
                sum = word[g*32 +: 8] + word[g*32+8 +: 8] + word[g*32+16 +: 8];
                if (sum != word[g*32+24 +: 8]) begin
                    bad = 1'b1;
                end
            end
            if (bad) begin
                res = cwvb_pkg::STATUS_CHECKSUM;
            end else if (word == '0) begin
                res = cwvb_pkg::STATUS_NULL;
            end else begin
                for (int i = 0; i < bl_fill; i++) begin
                    if (bl_low[i] == word[63:0] && bl_high[i] == word[127:64]) begin
                        res = cwvb_pkg::STATUS_BLACK;
                    end
                end
            end
        end
        return res;
    endfunction

    // builds a word whose four group checksums hold, from 12 data bytes
    function automatic logic [127:0] checked_word(logic [95:0] data);
        logic [127:0] word;
        logic [7:0]   b0, b1, b2;
        for (int g = 0; g < 4; g++) begin
            b0 = data[g*24 +: 8];
            b1 = data[g*24+8 +: 8];
            b2 = data[g*24+16 +: 8];
            word[g*32 +: 32] = {b2 + b1 + b0, b2, b1, b0};
        end
        return word;
    endfunction

    function automatic logic [127:0] random_checked_word();
        return checked_word({$urandom(), $urandom(), $urandom()});
    endfunction

    function automatic logic [127:0] random_raw_word();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // send one beat, with a random gap before a new burst
    task automatic send_beat(input cwvb_pkg::op_t op, input logic [127:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = sender_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        status_expected.push_back(predict_status(op, word));
        if (op == cwvb_pkg::OP_ADD) begin
            added_words.push_back(word);
            if (added_words.size() > WORD_CAP) begin
                void'(added_words.pop_front());
            end
        end
    endtask

    // hold the input side until all pending results are back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (status_expected.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // empty history: null, checksum errors, clean words and extremes
    task automatic test_empty_history();
        send_beat(cwvb_pkg::OP_CHECK, '0);
        send_beat(cwvb_pkg::OP_CHECK, '1);
        send_beat(cwvb_pkg::OP_CHECK, 128'h1 << 24);
        send_beat(cwvb_pkg::OP_CHECK, checked_word('1));
        send_beat(cwvb_pkg::OP_CHECK, checked_word(96'h0302_0100_0000_0000_0000_0001));
        send_beat(cwvb_pkg::OP_CHECK, checked_word(96'h80_8080_7f7f_7f01_0203_0405));
    endtask

    // a failure in each single group, the others clean
    task automatic test_group_checksum();
        logic [127:0] word;
        word = checked_word(96'h1122_3344_5566_7788_99aa_bbcc);
        for (int g = 0; g < 4; g++) begin
            send_beat(cwvb_pkg::OP_CHECK, word ^ (128'h1 << (g*32 + 24)));
            send_beat(cwvb_pkg::OP_CHECK, word ^ (128'h80 << (g*32 + 16)));
        end
    endtask

    // add stores anything; checksum before null before blacklisted
    task automatic test_add_priority();
        logic [127:0] word;
        word = checked_word('1);
        send_beat(cwvb_pkg::OP_CHECK, word);
        send_beat(cwvb_pkg::OP_ADD, word);
        send_beat(cwvb_pkg::OP_CHECK, word);
        send_beat(cwvb_pkg::OP_ADD, '0);
        send_beat(cwvb_pkg::OP_CHECK, '0);
        send_beat(cwvb_pkg::OP_ADD, '1);
        send_beat(cwvb_pkg::OP_CHECK, '1);
        send_beat(cwvb_pkg::OP_CHECK, word ^ (128'h1 << 127));
        wait_for_results();
    endtask

    // fill past the depth so the oldest entries drop out
    task automatic test_history_wrap();
        logic [127:0] words[$];
        logic [127:0] word;
        for (int i = 0; i < HIST_DEPTH + 8; i++) begin
            word = random_checked_word();
            words.push_back(word);
            send_beat(cwvb_pkg::OP_ADD, word);
        end
        for (int i = 0; i < 10; i++) begin
            send_beat(cwvb_pkg::OP_CHECK, words[i]);
        end
        send_beat(cwvb_pkg::OP_CHECK, words[words.size() - 1]);
        send_beat(cwvb_pkg::OP_CHECK, words[words.size() - HIST_DEPTH]);
        wait_for_results();
    endtask

    // mostly clean words and history hits, with noise and broken words
    task automatic test_mixed_traffic(input int count);
        int           pick;
        logic [127:0] word;
        for (int i = 0; i < count; i++) begin
            sender_steady = ((i / 100) % 4) == 3;
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                send_beat(cwvb_pkg::OP_ADD, random_checked_word());
            end else if (pick < 27) begin
                send_beat(cwvb_pkg::OP_ADD, random_raw_word());
            end else if (pick < 57) begin
                if (added_words.size() != 0) begin
                    word = added_words[$urandom_range(0, added_words.size() - 1)];
                end else begin
                    word = random_checked_word();
                end
                send_beat(cwvb_pkg::OP_CHECK, word);
            end else if (pick < 77) begin
                send_beat(cwvb_pkg::OP_CHECK, random_checked_word());
            end else if (pick < 87) begin
                send_beat(cwvb_pkg::OP_CHECK, random_raw_word());
            end else if (pick < 95) begin
                word = random_checked_word();
                send_beat(cwvb_pkg::OP_CHECK, word ^ (128'h1 << $urandom_range(0, 127)));
            end else begin
                send_beat(($urandom_range(0, 3) == 0) ? cwvb_pkg::OP_ADD
                                                      : cwvb_pkg::OP_CHECK, '0);
            end
            if (i % 250 == 249) begin
                wait_for_results();
            end
        end
        sender_steady = 1'b0;
    endtask

    // result checking and receiver stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (status_expected.size() == 0) begin
                $error("unexpected result beat: status %0d", m_tdata[1:0]);
                mismatches++;
            end else begin
                if (m_tdata[1:0] != status_expected[0]) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           status_expected[0], m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[7:2] != '0) begin
                    $error("pad mismatch: expected 0, actual %0d", m_tdata[7:2]);
                    mismatches++;
                end
                void'(status_expected.pop_front());
            end
        end
        rx_cycle++;
        if (rx_cycle % 64 == 0) begin
            rx_mode = $urandom_range(0, 2);
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
                m_tready <= (rx_cycle % 5) < 2;
            end
        endcase
    end

    // run limit
    initial begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main sequence
    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        mismatches    = 0;
        burst_left    = 0;
        sender_steady = 1'b0;
        rx_mode       = 0;
        rx_cycle      = 0;
        bl_fill       = 0;
        bl_slot       = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_history();
        test_group_checksum();
        test_add_priority();
        test_history_wrap();
        test_mixed_traffic(1000);

        wait_for_results();
        repeat (HIST_DEPTH + 8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
